// File: rtl/core/cspc_pkg.sv
// Shared widths and the side-band record for the cubic surface point check.
// Used by cubic_surface_point_check_top, cspc_udiv and cspc_isqrt.
`default_nettype none

package cspc_pkg;

  // Field widths
  localparam int D_W   = 35;          // candidate sum d
  localparam int Z_W   = 33;          // coordinate z
  localparam int CO_W  = 20;          // coefficient a
  localparam int OUT_W = 52;          // recovered x / y

  // Datapath widths
  localparam int NUM_W   = 97;                 // |1 - z^3|
  localparam int DV_W    = 54;                 // |d| * a
  localparam int D2_W    = 69;                 // d^2
  localparam int CN_W    = NUM_W + 1;          // |d^2 - lhs|
  localparam int DISC_W  = CN_W + 2;           // discriminant
  localparam int ROOT_W  = DISC_W / 2;         // integer root
  localparam int SQR_W   = ROOT_W + 2;         // root remainder
  localparam int XY_W    = 76;                 // curve coordinate -9at^4 - 3t

  // Divide-by-3 stage slicing
  localparam int D3_BITS   = 7;
  localparam int D3_STAGES = CN_W / D3_BITS;

  // Values that ride alongside the long arithmetic pipelines
  typedef struct packed {
    logic                    keep;   // item still a candidate
    logic                    neg;    // sign of the value in flight
    logic [D2_W-1:0]         d2;
    logic signed [D_W-1:0]   d;
    logic                    ch;     // on-curve preconditions hold
    logic signed [XY_W-1:0]  xy;     // curve coordinate to compare against
  } side_t;

endpackage

`default_nettype wire

// File: rtl/core/cspc_udiv.sv
// Restoring divider pipeline, one quotient bit per stage.
// Depends on cspc_pkg (widths, side_t).
`default_nettype none

module cspc_udiv import cspc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DV_W-1:0]   in_dv,
  input  wire side_t             in_side,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       out_quo,
  output logic                   out_rem_zero,
  output side_t                  out_side
);

  logic [NUM_W-1:0] v_r;
  logic [NUM_W-1:0] nq_r   [NUM_W];
  logic [DV_W-1:0]  rm_r   [NUM_W];
  logic [DV_W-1:0]  dv_r   [NUM_W];
  side_t            sd_r   [NUM_W];
  logic [NUM_W-1:0] nq_nxt [NUM_W];
  logic [DV_W-1:0]  rm_nxt [NUM_W];

  // One shift / compare / subtract step per stage
  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    logic [NUM_W-1:0] nq_in;
    logic [DV_W-1:0]  rm_in;
    logic [DV_W-1:0]  dv_in;
    logic [DV_W:0]    r2;
    logic             ge;
    if (i == 0) begin : g_head
      assign nq_in = in_num;
      assign rm_in = '0;
      assign dv_in = in_dv;
    end else begin : g_body
      assign nq_in = nq_r[i-1];
      assign rm_in = rm_r[i-1];
      assign dv_in = dv_r[i-1];
    end
    assign r2        = {rm_in, nq_in[NUM_W-1]};
    assign ge        = (r2 >= {1'b0, dv_in});
    assign nq_nxt[i] = {nq_in[NUM_W-2:0], ge};
    assign rm_nxt[i] = ge ? DV_W'(r2 - {1'b0, dv_in}) : r2[DV_W-1:0];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NUM_W-2:0], in_valid};
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_W; i++) begin
        nq_r[i] <= nq_nxt[i];
        rm_r[i] <= rm_nxt[i];
        if (i == 0) begin
          dv_r[i] <= in_dv;
          sd_r[i] <= in_side;
        end else begin
          dv_r[i] <= dv_r[i-1];
          sd_r[i] <= sd_r[i-1];
        end
      end
    end
  end

  assign out_valid    = v_r[NUM_W-1];
  assign out_quo      = nq_r[NUM_W-1];
  assign out_rem_zero = (rm_r[NUM_W-1] == '0);
  assign out_side     = sd_r[NUM_W-1];

endmodule

`default_nettype wire

// File: rtl/core/cspc_isqrt.sv
// Digit-by-digit integer square root pipeline, one root bit per stage.
// Depends on cspc_pkg (widths, side_t).
`default_nettype none

module cspc_isqrt import cspc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [DISC_W-1:0]  in_disc,
  input  wire side_t              in_side,
  output logic                    out_valid,
  output logic [ROOT_W-1:0]       out_root,
  output logic                    out_exact,
  output side_t                   out_side
);

  logic [ROOT_W-1:0] v_r;
  logic [DISC_W-1:0] dsh_r   [ROOT_W];
  logic [ROOT_W-1:0] rt_r    [ROOT_W];
  logic [SQR_W-1:0]  rm_r    [ROOT_W];
  side_t             sd_r    [ROOT_W];
  logic [DISC_W-1:0] dsh_nxt [ROOT_W];
  logic [ROOT_W-1:0] rt_nxt  [ROOT_W];
  logic [SQR_W-1:0]  rm_nxt  [ROOT_W];

  // Bring down two radicand bits, try root*4+1
  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic [DISC_W-1:0] dsh_in;
    logic [ROOT_W-1:0] rt_in;
    logic [SQR_W-1:0]  rm_in;
    logic [SQR_W+1:0]  cand;
    logic [SQR_W+1:0]  trial;
    logic              ge;
    if (i == 0) begin : g_head
      assign dsh_in = in_disc;
      assign rt_in  = '0;
      assign rm_in  = '0;
    end else begin : g_body
      assign dsh_in = dsh_r[i-1];
      assign rt_in  = rt_r[i-1];
      assign rm_in  = rm_r[i-1];
    end
    assign cand       = {rm_in, dsh_in[DISC_W-1 -: 2]};
    assign trial      = (SQR_W+2)'({rt_in, 2'b01});
    assign ge         = (cand >= trial);
    assign rm_nxt[i]  = ge ? SQR_W'(cand - trial) : SQR_W'(cand);
    assign rt_nxt[i]  = {rt_in[ROOT_W-2:0], ge};
    assign dsh_nxt[i] = {dsh_in[DISC_W-3:0], 2'b00};
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ROOT_W-2:0], in_valid};
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ROOT_W; i++) begin
        dsh_r[i] <= dsh_nxt[i];
        rt_r[i]  <= rt_nxt[i];
        rm_r[i]  <= rm_nxt[i];
        if (i == 0) begin
          sd_r[i] <= in_side;
        end else begin
          sd_r[i] <= sd_r[i-1];
        end
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = rt_r[ROOT_W-1];
  assign out_exact = (rm_r[ROOT_W-1] == '0);
  assign out_side  = sd_r[ROOT_W-1];

endmodule

`default_nettype wire

// File: rtl/core/cubic_surface_point_check_top.sv
// Cubic surface point check: a*x^3 + a*y^3 + z^3 = 1 for a candidate sum d.
// Throughput: one transaction per cycle while in_stall is low; the front, the
// 97-stage divider, the 14-stage divide-by-3 and the 50-stage root all advance
// together. An item with two results holds the output register until both
// results have been taken.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
`default_nettype none

module cubic_surface_point_check_top import cspc_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [D_W-1:0]   in_sum_xy,
  input  wire logic signed [Z_W-1:0]   in_z_coord,
  input  wire logic [CO_W-1:0]         in_coefficient,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [OUT_W-1:0]      out_x_coord,
  output logic signed [OUT_W-1:0]      out_y_coord,
  output logic                         out_last
);

  // Front widths
  localparam int FR_N      = 8;
  localparam int ZZ_W      = 2 * Z_W - 1;
  localparam int ZL_W      = Z_W;
  localparam int PL_W      = ZL_W + Z_W;
  localparam int PH_W      = ZZ_W - ZL_W + Z_W;
  localparam int DL_W      = 14;
  localparam int TQ_W      = 29;
  localparam int TQ_SH     = 16;
  localparam int TM_W      = TQ_W - TQ_SH;
  localparam int T2_W      = 2 * TM_W;
  localparam int T3_W      = 37;
  localparam int A9_W      = CO_W + 4;
  localparam int ZM1_W     = 61;
  localparam int ZC_W      = ZM1_W + 1;
  localparam int T4_W      = ZM1_W + TM_W;
  localparam int RECIP3    = 21846;     // ceil(2^16 / 3)
  localparam int DM_T_MAX  = 12290;     // |d| with |d/3| <= 4096

  typedef struct packed {
    logic                   keep;
    logic signed [D_W-1:0]  d;
    logic                   dn;
    logic [D_W-1:0]         dm;
    logic signed [Z_W-1:0]  z;
    logic                   zn;
    logic [Z_W-1:0]         zm;
    logic [CO_W-1:0]        co;
    logic [ZZ_W-1:0]        zz;
    logic [DV_W-1:0]        dam;
    logic [D2_W-1:0]        d2;
    logic [DL_W-1:0]        dl;
    logic [TQ_W-1:0]        tq;
    logic                   t_fits;
    logic [A9_W-1:0]        a9;
    logic [PL_W-1:0]        pl;
    logic [PH_W-1:0]        ph;
    logic [TM_W-1:0]        tm;
    logic                   d3ok;
    logic [NUM_W-1:0]       z3;
    logic [NUM_W-1:0]       nm;
    logic                   lneg;
    logic [T2_W-1:0]        t2;
    logic [T3_W-1:0]        t3;
    logic [ZM1_W-1:0]       zm1m;
    logic                   zmatch;
    logic [T4_W-1:0]        t4m;
    logic                   ch;
    logic signed [XY_W-1:0] xy;
  } fr_t;

  logic                 adv;
  logic [D_W-1:0]       dm_in;
  logic [Z_W-1:0]       zm_in;
  logic [FR_N-1:0]      fv_r;
  fr_t                  fr_r   [FR_N];
  fr_t                  fr_nxt [FR_N];

  side_t                div_side_in;
  logic                 div_valid;
  logic [NUM_W-1:0]     div_quo;
  logic                 div_rem_zero;
  side_t                div_side;

  logic                 p_v_r;
  logic [CN_W-1:0]      p_cn_r;
  side_t                p_sd_r;
  logic [CN_W-1:0]      p_cn_nxt;
  side_t                p_sd_nxt;

  logic [D3_STAGES-1:0] t_v_r;
  logic [CN_W-1:0]      t_nq_r   [D3_STAGES];
  logic [1:0]           t_rm_r   [D3_STAGES];
  side_t                t_sd_r   [D3_STAGES];
  logic [CN_W-1:0]      t_nq_nxt [D3_STAGES];
  logic [1:0]           t_rm_nxt [D3_STAGES];

  logic                 q_v_r;
  logic [DISC_W-1:0]    q_disc_r;
  side_t                q_sd_r;
  logic [DISC_W-1:0]    q_disc_nxt;
  side_t                q_sd_nxt;

  logic                 sq_valid;
  logic [ROOT_W-1:0]    sq_root;
  logic                 sq_exact;
  side_t                sq_side;

  logic                    z_v_r;
  logic signed [OUT_W-1:0] z_x_r;
  logic signed [OUT_W-1:0] z_y_r;
  logic                    z_two_r;
  logic                    z_keep_r;
  logic                    z_ch_r;
  logic signed [XY_W-1:0]  z_xy_r;
  logic signed [OUT_W-1:0] z_x_nxt;
  logic signed [OUT_W-1:0] z_y_nxt;

  logic                    fin_valid;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] ox_r;
  logic signed [OUT_W-1:0] oy_r;
  logic                    two_r;
  logic                    ph_r;

  // Seven-bit slice of a restoring divide by 3: {quotient bits, remainder}
  function automatic logic [D3_BITS+1:0] d3_step(input logic [1:0] rem,
                                                  input logic [D3_BITS-1:0] bits);
    logic [2:0]         r;
    logic [1:0]         rr;
    logic [D3_BITS-1:0] q;
    rr = rem;
    q  = '0;
    for (int k = D3_BITS - 1; k >= 0; k--) begin
      r = {rr, bits[k]};
      if (r >= 3'd3) begin
        rr   = 2'(r - 3'd3);
        q[k] = 1'b1;
      end else begin
        rr = r[1:0];
      end
    end
    return {q, rr};
  endfunction

  // Whole pipeline moves when the output register can take an item
  assign adv      = !out_valid_r || (!out_stall && out_last);
  assign in_stall = !adv;

  // Input magnitudes
  assign dm_in = in_sum_xy[D_W-1] ? (~in_sum_xy + D_W'(1)) : in_sum_xy;
  assign zm_in = in_z_coord[Z_W-1] ? (~in_z_coord + Z_W'(1)) : in_z_coord;

  // Front stages: cube of z, products, and the accumulating-curve terms
  always_comb begin
    logic                    nneg;
    logic                    tneg;
    logic signed [ZC_W-1:0]  zm1s;
    logic signed [ZC_W-1:0]  zlow;
    logic [XY_W-1:0]         tm3;

    fr_nxt[0]      = '0;
    fr_nxt[0].keep = (dm_in != '0) && (in_coefficient != '0);
    fr_nxt[0].d    = in_sum_xy;
    fr_nxt[0].dn   = in_sum_xy[D_W-1];
    fr_nxt[0].dm   = dm_in;
    fr_nxt[0].z    = in_z_coord;
    fr_nxt[0].zn   = in_z_coord[Z_W-1];
    fr_nxt[0].zm   = zm_in;
    fr_nxt[0].co   = in_coefficient;

    for (int k = 1; k < FR_N; k++) begin
      fr_nxt[k] = fr_r[k-1];
    end

    // z^2, |d|*a, d^2, reciprocal product for d/3, 9a
    fr_nxt[1].zz     = ZZ_W'(fr_r[0].zm) * ZZ_W'(fr_r[0].zm);
    fr_nxt[1].dam    = DV_W'(fr_r[0].dm) * DV_W'(fr_r[0].co);
    fr_nxt[1].d2     = D2_W'(fr_r[0].dm) * D2_W'(fr_r[0].dm);
    fr_nxt[1].dl     = fr_r[0].dm[DL_W-1:0];
    fr_nxt[1].tq     = TQ_W'(fr_r[0].dm[DL_W-1:0]) * TQ_W'(RECIP3);
    fr_nxt[1].t_fits = (fr_r[0].dm <= D_W'(DM_T_MAX));
    fr_nxt[1].a9     = A9_W'({fr_r[0].co, 3'b000}) + A9_W'(fr_r[0].co);

    // z^3 partial products, t = |d|/3 and its exactness
    fr_nxt[2].pl   = PL_W'(fr_r[1].zz[ZL_W-1:0]) * PL_W'(fr_r[1].zm);
    fr_nxt[2].ph   = PH_W'(fr_r[1].zz[ZZ_W-1:ZL_W]) * PH_W'(fr_r[1].zm);
    fr_nxt[2].tm   = fr_r[1].tq[TQ_W-1:TQ_SH];
    fr_nxt[2].d3ok = fr_r[1].t_fits &&
                     ((DL_W+1)'(fr_r[1].dl) ==
                      (DL_W+1)'(fr_r[1].tq[TQ_W-1:TQ_SH]) * (DL_W+1)'(3));

    // z^3 and t^2
    fr_nxt[3].z3 = NUM_W'(fr_r[2].pl) + (NUM_W'(fr_r[2].ph) << ZL_W);
    fr_nxt[3].t2 = T2_W'(fr_r[2].tm) * T2_W'(fr_r[2].tm);

    // 1 - z^3 as sign and magnitude, t^3
    nneg = 1'b0;
    if (fr_r[3].zn) begin
      fr_nxt[4].nm = fr_r[3].z3 + NUM_W'(1);
    end else if (fr_r[3].z3 == '0) begin
      fr_nxt[4].nm = NUM_W'(1);
    end else begin
      fr_nxt[4].nm = fr_r[3].z3 - NUM_W'(1);
      nneg         = (fr_r[3].z3 != NUM_W'(1));
    end
    fr_nxt[4].lneg = nneg ^ fr_r[3].dn;
    fr_nxt[4].t3   = T3_W'(fr_r[3].t2) * T3_W'(fr_r[3].tm);

    // 9*a*|t|^3
    fr_nxt[5].zm1m = ZM1_W'(fr_r[4].t3) * ZM1_W'(fr_r[4].a9);

    // z == 9at^3 + 1, and 9a|t|^4
    tneg                = !fr_r[5].dn;
    zm1s                = tneg ? -ZC_W'(fr_r[5].zm1m) : ZC_W'(fr_r[5].zm1m);
    zlow                = ZC_W'($signed(fr_r[5].z)) - ZC_W'(1);
    fr_nxt[6].zmatch    = (zm1s == zlow);
    fr_nxt[6].t4m       = T4_W'(fr_r[5].zm1m) * T4_W'(fr_r[5].tm);

    // Curve coordinate -9at^4 - 3t
    tneg         = !fr_r[6].dn;
    tm3          = XY_W'(fr_r[6].tm) * XY_W'(3);
    fr_nxt[7].xy = tneg ? $signed(tm3 - XY_W'(fr_r[6].t4m))
                        : $signed(-(XY_W'(fr_r[6].t4m) + tm3));
    fr_nxt[7].ch = fr_r[6].d3ok && fr_r[6].zmatch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (adv) begin
      fv_r <= {fv_r[FR_N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < FR_N; k++) begin
        fr_r[k] <= fr_nxt[k];
      end
    end
  end

  // (1 - z^3) / (|d| * a)
  always_comb begin
    div_side_in      = '0;
    div_side_in.keep = fr_r[FR_N-1].keep;
    div_side_in.neg  = fr_r[FR_N-1].lneg;
    div_side_in.d2   = fr_r[FR_N-1].d2;
    div_side_in.d    = fr_r[FR_N-1].d;
    div_side_in.ch   = fr_r[FR_N-1].ch;
    div_side_in.xy   = fr_r[FR_N-1].xy;
  end

  cspc_udiv u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .in_valid     (fv_r[FR_N-1]),
    .in_num       (fr_r[FR_N-1].nm),
    .in_dv        (fr_r[FR_N-1].dam),
    .in_side      (div_side_in),
    .out_valid    (div_valid),
    .out_quo      (div_quo),
    .out_rem_zero (div_rem_zero),
    .out_side     (div_side)
  );

  // d^2 - lhs
  always_comb begin
    logic            lneg;
    logic [CN_W-1:0] d2e;
    logic [CN_W-1:0] qe;
    lneg          = div_side.neg && (div_quo != '0);
    d2e           = CN_W'(div_side.d2);
    qe            = CN_W'(div_quo);
    p_sd_nxt      = div_side;
    p_sd_nxt.keep = div_side.keep && div_rem_zero;
    if (lneg) begin
      p_cn_nxt     = d2e + qe;
      p_sd_nxt.neg = 1'b0;
    end else if (d2e >= qe) begin
      p_cn_nxt     = d2e - qe;
      p_sd_nxt.neg = 1'b0;
    end else begin
      p_cn_nxt     = qe - d2e;
      p_sd_nxt.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_cn_r <= p_cn_nxt;
      p_sd_r <= p_sd_nxt;
    end
  end

  // Divide by 3, seven bits per stage
  for (genvar i = 0; i < D3_STAGES; i++) begin : g_d3
    logic [CN_W-1:0]      nq_in;
    logic [1:0]           rm_in;
    logic [D3_BITS+1:0]   res;
    if (i == 0) begin : g_head
      assign nq_in = p_cn_r;
      assign rm_in = '0;
    end else begin : g_body
      assign nq_in = t_nq_r[i-1];
      assign rm_in = t_rm_r[i-1];
    end
    assign res         = d3_step(rm_in, nq_in[CN_W-1 -: D3_BITS]);
    assign t_nq_nxt[i] = {nq_in[CN_W-D3_BITS-1:0], res[D3_BITS+1:2]};
    assign t_rm_nxt[i] = res[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= '0;
    end else if (adv) begin
      t_v_r <= {t_v_r[D3_STAGES-2:0], p_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < D3_STAGES; i++) begin
        t_nq_r[i] <= t_nq_nxt[i];
        t_rm_r[i] <= t_rm_nxt[i];
        if (i == 0) begin
          t_sd_r[i] <= p_sd_r;
        end else begin
          t_sd_r[i] <= t_sd_r[i-1];
        end
      end
    end
  end

  // Discriminant d^2 - 4*(d^2 - lhs)/3, must be non-negative
  always_comb begin
    logic [DISC_W-1:0] fct;
    logic [DISC_W-1:0] d2e;
    fct           = {t_nq_r[D3_STAGES-1], 2'b00};
    d2e           = DISC_W'(t_sd_r[D3_STAGES-1].d2);
    q_sd_nxt      = t_sd_r[D3_STAGES-1];
    q_sd_nxt.keep = t_sd_r[D3_STAGES-1].keep && (t_rm_r[D3_STAGES-1] == '0);
    if (t_sd_r[D3_STAGES-1].neg) begin
      q_disc_nxt = d2e + fct;
    end else if (d2e >= fct) begin
      q_disc_nxt = d2e - fct;
    end else begin
      q_disc_nxt    = '0;
      q_sd_nxt.keep = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= 1'b0;
    end else if (adv) begin
      q_v_r <= t_v_r[D3_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_disc_r <= q_disc_nxt;
      q_sd_r   <= q_sd_nxt;
    end
  end

  cspc_isqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (q_v_r),
    .in_disc   (q_disc_r),
    .in_side   (q_sd_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_exact (sq_exact),
    .out_side  (sq_side)
  );

  // x = (d + s) / 2 truncated toward zero, y = d - x
  always_comb begin
    logic signed [OUT_W-1:0] sum;
    logic signed [OUT_W-1:0] sum_adj;
    sum     = OUT_W'($signed(sq_side.d)) + OUT_W'(sq_root);
    sum_adj = sum + {{(OUT_W-1){1'b0}}, sum[OUT_W-1] & sum[0]};
    z_x_nxt = sum_adj >>> 1;
    z_y_nxt = OUT_W'($signed(sq_side.d)) - z_x_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_v_r <= 1'b0;
    end else if (adv) begin
      z_v_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z_x_r    <= z_x_nxt;
      z_y_r    <= z_y_nxt;
      z_two_r  <= (sq_root != '0);
      z_keep_r <= sq_side.keep && sq_exact;
      z_ch_r   <= sq_side.ch;
      z_xy_r   <= sq_side.xy;
    end
  end

  // Drop points on the accumulating curve
  assign fin_valid = z_v_r && z_keep_r &&
                     !(z_ch_r && ((XY_W'(z_x_r) == z_xy_r) || (XY_W'(z_y_r) == z_xy_r)));

  // Output register: (x,y), then (y,x) when the root is nonzero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ph_r        <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin_valid;
      ph_r        <= 1'b0;
    end else if (!out_stall) begin
      ph_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r  <= z_x_r;
      oy_r  <= z_y_r;
      two_r <= z_two_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x_coord = ph_r ? oy_r : ox_r;
  assign out_y_coord = ph_r ? ox_r : oy_r;
  assign out_last    = !two_r || ph_r;

`ifndef ASSERT_OFF
  // Empty output register never back-pressures the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // First result of a pair is always followed by the closing one
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && out_last)
    else $error("second result of a pair missing");

  // Second result swaps the coordinates of the first
  a_pair_swapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_x_coord == $past(out_y_coord) && out_y_coord == $past(out_x_coord))
    else $error("second result is not the swapped pair");
`endif

endmodule

`default_nettype wire
